>>> rtl/gdda_pkg.sv
// Shared types, constants and command codes for the grid DDA wall raycaster.
`timescale 1ns / 1ps
package gdda_pkg;

	localparam int MAP_DIM_DEF    = 32;
	localparam int TEX_SIZE_DEF   = 64;
	localparam int MAX_SCREEN_DEF = 2048;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [20:0] POS_X_RST   = 21'd1441792;
	localparam logic [20:0] POS_Y_RST   = 21'd786432;
	localparam logic [15:0] DIR_X_RST   = 16'hC000;
	localparam logic [15:0] DIR_Y_RST   = 16'h0000;
	localparam logic [15:0] PLANE_X_RST = 16'h0000;
	localparam logic [15:0] PLANE_Y_RST = 16'd10813;
	localparam logic [11:0] SCR_W_RST   = 12'd640;
	localparam logic [11:0] SCR_H_RST   = 12'd480;

	localparam logic [23:0] DELTA_MAX = 24'hFFFFFF;
	localparam logic [22:0] STEP_MAX  = 23'h7FFFFF;
	localparam logic [21:0] START_MAX = 22'h3FFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_DIR_X   = 3'd2,
		REG_DIR_Y   = 3'd3,
		REG_PLANE_X = 3'd4,
		REG_PLANE_Y = 3'd5,
		REG_SCR_W   = 3'd6,
		REG_SCR_H   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OPC_TILE = 1'b0,
		OPC_CAST = 1'b1
	} opc_t;

	typedef struct packed {
		logic        opcode;
		logic [10:0] column;
		logic [4:0]  cell_x;
		logic [4:0]  cell_y;
		logic [3:0]  tile_kind;
	} in_item_t;

	typedef struct packed {
		logic [10:0] column_out;
		logic [10:0] draw_start;
		logic [10:0] draw_end;
		logic [3:0]  texture_index;
		logic [5:0]  texture_column;
		logic        side_hit;
		logic [22:0] tex_step;
		logic [21:0] tex_start;
		logic        status;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_CAM_GO,
		OP_CAM_END,
		OP_RAY_MUL,
		OP_RAY_ADD,
		OP_DX_GO,
		OP_DX_END,
		OP_DY_GO,
		OP_DY_END,
		OP_SIDE_MUL,
		OP_SIDE_SET,
		OP_STEP,
		OP_READ,
		OP_PERP,
		OP_LINE_GO,
		OP_LINE_END,
		OP_SPAN,
		OP_WALL,
		OP_TSTEP_GO,
		OP_TSTEP_END,
		OP_START_MUL,
		OP_START_SAT,
		OP_EMIT,
		OP_MISS
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAST,
		ST_CAM_WAIT,
		ST_RAY_MUL,
		ST_RAY_ADD,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_SIDE_MUL,
		ST_SIDE_SET,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_PERP,
		ST_LINE_GO,
		ST_LINE_WAIT,
		ST_SPAN,
		ST_WALL,
		ST_TSTEP_GO,
		ST_TSTEP_WAIT,
		ST_START_MUL,
		ST_START_SAT,
		ST_EMIT,
		ST_MISS
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_cast;
		logic off_screen;
		logic viewer_out;
		logic clear_done;
		logic div_done;
		logic out_map;
		logic hit;
		logic walk_last;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/gdda_stream_if.sv
// Valid/ready request channel carrying one payload item.
`timescale 1ns / 1ps
interface gdda_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/grid_dda_wall_raycaster_top.sv
// Grid DDA wall raycaster, one wall slice per cast request.
// After reset the tile map is swept to floor, one cell per cycle, and no request is
// taken until the sweep ends; configuration writes are taken at any time. A cast runs
// five divisions (camera x, two ray deltas, line height, texture step) and a DDA walk
// of at most 2*MAP_DIM+2 grid steps (DIV_W is 32 with the default map). The divisions go
// through one shared restoring divider that yields one quotient bit per cycle, and each
// DDA step needs a tile map read. One request is in work at a time; a finished slice
// waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module grid_dda_wall_raycaster_top #(
	parameter int MAP_DIM    = gdda_pkg::MAP_DIM_DEF,
	parameter int TEX_SIZE   = gdda_pkg::TEX_SIZE_DEF,
	parameter int MAX_SCREEN = gdda_pkg::MAX_SCREEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gdda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gdda_pkg::CFG_DATA_W-1:0] cfg_data,
	gdda_stream_if.sink                     in_ch,
	gdda_stream_if.source                   out_ch
);
	gdda_pkg::dp_cmd_t  cmd;
	gdda_pkg::dp_stat_t stat;

	gdda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gdda_dp #(
		.MAP_DIM    (MAP_DIM),
		.TEX_SIZE   (TEX_SIZE),
		.MAX_SCREEN (MAX_SCREEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_ch.data),
		.out_data  (out_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule

>>> rtl/gdda_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gdda_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quot
);
	localparam int CNT_W = $clog2(W + 1);

	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       shifted;
	logic [W+1:0]     trial;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign trial   = {1'b0, shifted} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W+1]) begin
				rem_q <= trial[W:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

>>> rtl/gdda_ctrl.sv
// Sequencer for tile writes, map clear and the per-column ray cast.
`timescale 1ns / 1ps
module gdda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gdda_pkg::dp_stat_t stat,
	output gdda_pkg::dp_cmd_t  cmd
);
	gdda_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gdda_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = gdda_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			gdda_pkg::ST_CLEAR: begin
				cmd.op = gdda_pkg::OP_CLEAR;
				if (stat.clear_done)
					state_d = gdda_pkg::ST_IDLE;
			end
			gdda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = gdda_pkg::OP_LOAD;
					state_d = gdda_pkg::ST_CAST;
				end
			end
			gdda_pkg::ST_CAST: begin
				if (!stat.is_cast || stat.off_screen) begin
					state_d = gdda_pkg::ST_IDLE;
				end else if (stat.viewer_out) begin
					state_d = gdda_pkg::ST_MISS;
				end else begin
					cmd.op  = gdda_pkg::OP_CAM_GO;
					state_d = gdda_pkg::ST_CAM_WAIT;
				end
			end
			gdda_pkg::ST_CAM_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = gdda_pkg::OP_CAM_END;
					state_d = gdda_pkg::ST_RAY_MUL;
				end
			end
			gdda_pkg::ST_RAY_MUL: begin
				cmd.op  = gdda_pkg::OP_RAY_MUL;
				state_d = gdda_pkg::ST_RAY_ADD;
			end
			gdda_pkg::ST_RAY_ADD: begin
				cmd.op  = gdda_pkg::OP_RAY_ADD;
				state_d = gdda_pkg::ST_DX_GO;
			end
			gdda_pkg::ST_DX_GO: begin
				cmd.op  = gdda_pkg::OP_DX_GO;
				state_d = gdda_pkg::ST_DX_WAIT;
			end
			gdda_pkg::ST_DX_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = gdda_pkg::OP_DX_END;
					state_d = gdda_pkg::ST_DY_GO;
				end
			end
			gdda_pkg::ST_DY_GO: begin
				cmd.op  = gdda_pkg::OP_DY_GO;
				state_d = gdda_pkg::ST_DY_WAIT;
			end
			gdda_pkg::ST_DY_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = gdda_pkg::OP_DY_END;
					state_d = gdda_pkg::ST_SIDE_MUL;
				end
			end
			gdda_pkg::ST_SIDE_MUL: begin
				cmd.op  = gdda_pkg::OP_SIDE_MUL;
				state_d = gdda_pkg::ST_SIDE_SET;
			end
			gdda_pkg::ST_SIDE_SET: begin
				cmd.op  = gdda_pkg::OP_SIDE_SET;
				state_d = gdda_pkg::ST_STEP;
			end
			gdda_pkg::ST_STEP: begin
				cmd.op  = gdda_pkg::OP_STEP;
				state_d = gdda_pkg::ST_READ;
			end
			gdda_pkg::ST_READ: begin
				if (stat.out_map) begin
					state_d = gdda_pkg::ST_MISS;
				end else begin
					cmd.op  = gdda_pkg::OP_READ;
					state_d = gdda_pkg::ST_CHECK;
				end
			end
			gdda_pkg::ST_CHECK: begin
				if (stat.hit)
					state_d = gdda_pkg::ST_PERP;
				else if (stat.walk_last)
					state_d = gdda_pkg::ST_MISS;
				else
					state_d = gdda_pkg::ST_STEP;
			end
			gdda_pkg::ST_PERP: begin
				cmd.op  = gdda_pkg::OP_PERP;
				state_d = gdda_pkg::ST_LINE_GO;
			end
			gdda_pkg::ST_LINE_GO: begin
				cmd.op  = gdda_pkg::OP_LINE_GO;
				state_d = gdda_pkg::ST_LINE_WAIT;
			end
			gdda_pkg::ST_LINE_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = gdda_pkg::OP_LINE_END;
					state_d = gdda_pkg::ST_SPAN;
				end
			end
			gdda_pkg::ST_SPAN: begin
				cmd.op  = gdda_pkg::OP_SPAN;
				state_d = gdda_pkg::ST_WALL;
			end
			gdda_pkg::ST_WALL: begin
				cmd.op  = gdda_pkg::OP_WALL;
				state_d = gdda_pkg::ST_TSTEP_GO;
			end
			gdda_pkg::ST_TSTEP_GO: begin
				cmd.op  = gdda_pkg::OP_TSTEP_GO;
				state_d = gdda_pkg::ST_TSTEP_WAIT;
			end
			gdda_pkg::ST_TSTEP_WAIT: begin
				if (stat.div_done) begin
					cmd.op  = gdda_pkg::OP_TSTEP_END;
					state_d = gdda_pkg::ST_START_MUL;
				end
			end
			gdda_pkg::ST_START_MUL: begin
				cmd.op  = gdda_pkg::OP_START_MUL;
				state_d = gdda_pkg::ST_START_SAT;
			end
			gdda_pkg::ST_START_SAT: begin
				cmd.op  = gdda_pkg::OP_START_SAT;
				state_d = gdda_pkg::ST_EMIT;
			end
			gdda_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op  = gdda_pkg::OP_EMIT;
					state_d = gdda_pkg::ST_IDLE;
				end
			end
			gdda_pkg::ST_MISS: begin
				if (stat.out_free) begin
					cmd.op  = gdda_pkg::OP_MISS;
					state_d = gdda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gdda_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

>>> rtl/gdda_dp.sv
// Datapath: config registers, tile map, DDA walk, divider and slice math.
`timescale 1ns / 1ps
module gdda_dp #(
	parameter int MAP_DIM    = gdda_pkg::MAP_DIM_DEF,
	parameter int TEX_SIZE   = gdda_pkg::TEX_SIZE_DEF,
	parameter int MAX_SCREEN = gdda_pkg::MAX_SCREEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gdda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gdda_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  gdda_pkg::in_item_t                 in_data,
	output gdda_pkg::out_item_t                out_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	input  gdda_pkg::dp_cmd_t                  cmd,
	output gdda_pkg::dp_stat_t                 stat
);
	localparam int SCR_W    = $clog2(MAX_SCREEN) + 1;
	localparam int MC_W     = $clog2(MAP_DIM) + 2;
	localparam int DEPTH    = MAP_DIM * MAP_DIM;
	localparam int A_W      = $clog2(DEPTH);
	localparam int WALK_MAX = 2 * MAP_DIM + 2;
	localparam int N_W      = $clog2(WALK_MAX + 1);
	localparam int SD_W     = 24 + N_W + 1;
	localparam int LN_W     = SCR_W + 16;
	localparam int TX_W     = $clog2(TEX_SIZE);
	localparam int DIV_W    = (SD_W > 31) ? SD_W : 31;
	localparam int PW_W     = SD_W + 1 + 18;
	localparam int OFF_LIM  = 1 << 22;

	// configuration
	logic [20:0]        pos_x_q, pos_y_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [11:0]        scr_w_q, scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= gdda_pkg::POS_X_RST;
			pos_y_q   <= gdda_pkg::POS_Y_RST;
			dir_x_q   <= gdda_pkg::DIR_X_RST;
			dir_y_q   <= gdda_pkg::DIR_Y_RST;
			plane_x_q <= gdda_pkg::PLANE_X_RST;
			plane_y_q <= gdda_pkg::PLANE_Y_RST;
			scr_w_q   <= gdda_pkg::SCR_W_RST;
			scr_h_q   <= gdda_pkg::SCR_H_RST;
		end else if (cfg_we) begin
			case (gdda_pkg::cfg_reg_t'(cfg_index))
				gdda_pkg::REG_POS_X:   pos_x_q   <= cfg_data;
				gdda_pkg::REG_POS_Y:   pos_y_q   <= cfg_data;
				gdda_pkg::REG_DIR_X:   dir_x_q   <= cfg_data[15:0];
				gdda_pkg::REG_DIR_Y:   dir_y_q   <= cfg_data[15:0];
				gdda_pkg::REG_PLANE_X: plane_x_q <= cfg_data[15:0];
				gdda_pkg::REG_PLANE_Y: plane_y_q <= cfg_data[15:0];
				gdda_pkg::REG_SCR_W:   scr_w_q   <= cfg_data[11:0];
				gdda_pkg::REG_SCR_H:   scr_h_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	logic [SCR_W-1:0] w_eff, h_eff;

	always_comb begin
		if (scr_w_q == '0)
			w_eff = SCR_W'(1);
		else if (int'(scr_w_q) > MAX_SCREEN)
			w_eff = SCR_W'(MAX_SCREEN);
		else
			w_eff = SCR_W'(scr_w_q);
		if (scr_h_q == '0)
			h_eff = SCR_W'(1);
		else if (int'(scr_h_q) > MAX_SCREEN)
			h_eff = SCR_W'(MAX_SCREEN);
		else
			h_eff = SCR_W'(scr_h_q);
	end

	// working registers
	logic [10:0]              col_q;
	logic                     cast_q;
	logic signed [15:0]       cam_q;
	logic signed [31:0]       prx_s1, pry_s1;
	logic signed [17:0]       rx_q, ry_q;
	logic [23:0]              dx_q, dy_q;
	logic [40:0]              psx_s1, psy_s1;
	logic [SD_W-1:0]          sdx_q, sdy_q, perp_q;
	logic signed [MC_W-1:0]   mx_q, my_q;
	logic [N_W-1:0]           n_q;
	logic                     side_q;
	logic [3:0]               rd_q;
	logic [LN_W-1:0]          line_q;
	logic [SCR_W-1:0]         ds_q, de_q;
	logic [22:0]              off_q;
	logic signed [PW_W-1:0]   pw_s1;
	logic [TX_W-1:0]          txc_q;
	logic [22:0]              step_q;
	logic [45:0]              ps_s1;
	logic [21:0]              start_q;
	logic [A_W-1:0]           clr_q;
	gdda_pkg::out_item_t      out_q;
	logic                     out_valid_q;

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_num, div_den, div_quot;
	logic             div_done;

	logic signed [13:0] cam_diff;
	logic [12:0]        cam_mag;
	logic [16:0]        abs_rx, abs_ry;

	assign cam_diff = $signed({2'b0, col_q, 1'b0}) - $signed({1'b0, 13'(w_eff)});
	assign cam_mag  = cam_diff[13] ? 13'(-cam_diff) : 13'(cam_diff);
	assign abs_rx   = rx_q[17] ? 17'(-rx_q) : 17'(rx_q);
	assign abs_ry   = ry_q[17] ? 17'(-ry_q) : 17'(ry_q);

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			gdda_pkg::OP_CAM_GO: begin
				div_start = 1'b1;
				div_num   = DIV_W'({cam_mag, 14'b0});
				div_den   = DIV_W'(w_eff);
			end
			gdda_pkg::OP_DX_GO: begin
				div_start = 1'b1;
				div_num   = DIV_W'(2 ** 30);
				div_den   = DIV_W'(abs_rx);
			end
			gdda_pkg::OP_DY_GO: begin
				div_start = 1'b1;
				div_num   = DIV_W'(2 ** 30);
				div_den   = DIV_W'(abs_ry);
			end
			gdda_pkg::OP_LINE_GO: begin
				div_start = 1'b1;
				div_num   = DIV_W'({h_eff, 16'b0});
				div_den   = DIV_W'(perp_q);
			end
			gdda_pkg::OP_TSTEP_GO: begin
				div_start = 1'b1;
				div_num   = DIV_W'(TEX_SIZE * 65536);
				div_den   = (line_q == '0) ? DIV_W'(1) : DIV_W'(line_q);
			end
			default: ;
		endcase
	end

	gdda_div #(.W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// tile map
	logic [3:0]     mem [DEPTH];
	logic           mem_we;
	logic [A_W-1:0] mem_wa, map_addr;
	logic [3:0]     mem_wd;

	assign map_addr = A_W'(int'(my_q) * MAP_DIM + int'(mx_q));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (cmd.op == gdda_pkg::OP_CLEAR) begin
			mem_we = 1'b1;
		end else if (cmd.op == gdda_pkg::OP_LOAD && in_data.opcode == gdda_pkg::OPC_TILE
				&& int'(in_data.cell_x) < MAP_DIM && int'(in_data.cell_y) < MAP_DIM) begin
			mem_we = 1'b1;
			mem_wa = A_W'(int'(in_data.cell_y) * MAP_DIM + int'(in_data.cell_x));
			mem_wd = in_data.tile_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (cmd.op == gdda_pkg::OP_READ)
			rd_q <= mem[map_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.op == gdda_pkg::OP_CLEAR)
			clr_q <= clr_q + 1'b1;
	end

	// slice math helpers
	logic [16:0]        frx, fry;
	logic [SD_W-1:0]    perp_raw;
	logic [SCR_W-1:0]   half_h;
	logic [LN_W-1:0]    half_l;
	logic [LN_W:0]      de_sum;
	logic [LN_W-1:0]    off_raw;
	logic [15:0]        wall_frac;
	logic [TX_W-1:0]    tx_raw;
	logic               mirror;

	assign frx      = rx_q[17] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
	assign fry      = ry_q[17] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};
	assign perp_raw = side_q ? sdy_q - SD_W'(dy_q) : sdx_q - SD_W'(dx_q);
	assign half_h   = h_eff >> 1;
	assign half_l   = line_q >> 1;
	assign de_sum   = {1'b0, half_l} + (LN_W + 1)'(half_h);
	assign off_raw  = (half_l >= LN_W'(half_h)) ? half_l - LN_W'(half_h) : '0;
	assign wall_frac = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + 16'(pw_s1 >>> 14);
	assign tx_raw   = TX_W'((32'(wall_frac) * TEX_SIZE) >> 16);
	assign mirror   = (!side_q && !rx_q[17] && rx_q != '0) || (side_q && ry_q[17]);

	always_ff @(posedge clk) begin
		case (cmd.op)
			gdda_pkg::OP_LOAD: begin
				col_q  <= in_data.column;
				cast_q <= in_data.opcode;
			end
			gdda_pkg::OP_CAM_END:
				cam_q <= cam_diff[13] ? -16'(div_quot) : 16'(div_quot);
			gdda_pkg::OP_RAY_MUL: begin
				prx_s1 <= plane_x_q * cam_q;
				pry_s1 <= plane_y_q * cam_q;
			end
			gdda_pkg::OP_RAY_ADD: begin
				rx_q <= 18'(dir_x_q) + 18'(prx_s1 >>> 14);
				ry_q <= 18'(dir_y_q) + 18'(pry_s1 >>> 14);
			end
			gdda_pkg::OP_DX_END:
				dx_q <= (abs_rx == '0 || div_quot > DIV_W'(gdda_pkg::DELTA_MAX))
					? gdda_pkg::DELTA_MAX : 24'(div_quot);
			gdda_pkg::OP_DY_END:
				dy_q <= (abs_ry == '0 || div_quot > DIV_W'(gdda_pkg::DELTA_MAX))
					? gdda_pkg::DELTA_MAX : 24'(div_quot);
			gdda_pkg::OP_SIDE_MUL: begin
				psx_s1 <= 41'(frx) * 41'(dx_q);
				psy_s1 <= 41'(fry) * 41'(dy_q);
			end
			gdda_pkg::OP_SIDE_SET: begin
				sdx_q  <= SD_W'(psx_s1 >> 16);
				sdy_q  <= SD_W'(psy_s1 >> 16);
				mx_q   <= MC_W'($signed({1'b0, pos_x_q[20:16]}));
				my_q   <= MC_W'($signed({1'b0, pos_y_q[20:16]}));
				n_q    <= '0;
				side_q <= 1'b0;
			end
			gdda_pkg::OP_STEP: begin
				n_q <= n_q + 1'b1;
				if (sdx_q < sdy_q) begin
					sdx_q  <= sdx_q + SD_W'(dx_q);
					mx_q   <= rx_q[17] ? mx_q - 1'b1 : mx_q + 1'b1;
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sdy_q + SD_W'(dy_q);
					my_q   <= ry_q[17] ? my_q - 1'b1 : my_q + 1'b1;
					side_q <= 1'b1;
				end
			end
			gdda_pkg::OP_PERP:
				perp_q <= (perp_raw == '0) ? SD_W'(1) : perp_raw;
			gdda_pkg::OP_LINE_END:
				line_q <= LN_W'(div_quot);
			gdda_pkg::OP_SPAN: begin
				ds_q  <= (half_l >= LN_W'(half_h)) ? '0 : half_h - SCR_W'(half_l);
				de_q  <= (de_sum >= (LN_W + 1)'(h_eff)) ? h_eff - 1'b1 : SCR_W'(de_sum);
				off_q <= (int'(off_raw) > OFF_LIM) ? 23'(OFF_LIM) : 23'(off_raw);
				pw_s1 <= $signed({1'b0, perp_q}) * (side_q ? rx_q : ry_q);
			end
			gdda_pkg::OP_WALL:
				txc_q <= mirror ? TX_W'(TEX_SIZE - 1) - tx_raw : tx_raw;
			gdda_pkg::OP_TSTEP_END:
				step_q <= (div_quot > DIV_W'(gdda_pkg::STEP_MAX))
					? gdda_pkg::STEP_MAX : 23'(div_quot);
			gdda_pkg::OP_START_MUL:
				ps_s1 <= 46'(off_q) * 46'(step_q);
			gdda_pkg::OP_START_SAT:
				start_q <= (ps_s1 > 46'(gdda_pkg::START_MAX))
					? gdda_pkg::START_MAX : 22'(ps_s1);
			gdda_pkg::OP_EMIT: begin
				out_q.column_out     <= col_q;
				out_q.draw_start     <= 11'(ds_q);
				out_q.draw_end       <= 11'(de_q);
				out_q.texture_index  <= rd_q - 1'b1;
				out_q.texture_column <= 6'(txc_q);
				out_q.side_hit       <= side_q;
				out_q.tex_step       <= step_q;
				out_q.tex_start      <= start_q;
				out_q.status         <= 1'b0;
			end
			gdda_pkg::OP_MISS: begin
				out_q.column_out     <= col_q;
				out_q.draw_start     <= '0;
				out_q.draw_end       <= '0;
				out_q.texture_index  <= '0;
				out_q.texture_column <= '0;
				out_q.side_hit       <= 1'b0;
				out_q.tex_step       <= '0;
				out_q.tex_start      <= '0;
				out_q.status         <= 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == gdda_pkg::OP_EMIT || cmd.op == gdda_pkg::OP_MISS)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.is_cast    = cast_q;
	assign stat.off_screen = int'(col_q) >= int'(w_eff);
	assign stat.viewer_out = int'(pos_x_q[20:16]) >= MAP_DIM || int'(pos_y_q[20:16]) >= MAP_DIM;
	assign stat.clear_done = (clr_q == A_W'(DEPTH - 1));
	assign stat.div_done   = div_done;
	assign stat.out_map    = mx_q < 0 || int'(mx_q) >= MAP_DIM
	                      || my_q < 0 || int'(my_q) >= MAP_DIM;
	assign stat.hit        = (rd_q != '0);
	assign stat.walk_last  = (n_q == N_W'(WALK_MAX));
	assign stat.out_free   = !out_valid_q || out_ready;
endmodule

>>> rtl/gdda_chk.sv
// Port-level checker for the raycaster, bound to the top level.
`timescale 1ns / 1ps
module gdda_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input gdda_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in work");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |->
			out_data.draw_start == '0 && out_data.draw_end == '0
			&& out_data.tex_step == '0 && out_data.tex_start == '0
			&& out_data.texture_column == '0 && out_data.side_hit == 1'b0)
		else $error("miss result carries nonzero slice fields");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.status |-> out_data.draw_start <= out_data.draw_end)
		else $error("draw start past draw end");

	a_tex_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.status |-> out_data.texture_index != 4'hF)
		else $error("hit reported on floor tile");
endmodule

bind grid_dda_wall_raycaster_top gdda_chk u_gdda_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
